[rtl/core/kdb_pkg.sv]
// ----------------------------------------------------------------------------
// kdb_pkg: shared types and constants for the keypad debounce digit buffer
// Command codes, configuration register indexes and field widths used by the
// channel interfaces and the block itself.
// ----------------------------------------------------------------------------
`default_nettype none

package kdb_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned BIDX_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [KEY_W-1:0]  key_word_t;
  typedef logic [BIDX_W-1:0] bit_idx_t;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 3'd0,
    CMD_CLR_ENTER  = 3'd1,
    CMD_CLR_CANCEL = 3'd2,
    CMD_CLR_STORE  = 3'd3,
    CMD_READ       = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_DIGIT = 2'd0,
    REG_LAST_DIGIT  = 2'd1,
    REG_ENTER_BIT   = 2'd2,
    REG_CANCEL_BIT  = 2'd3
  } reg_idx_t;

  // Reset values of the configuration registers.
  localparam bit_idx_t FIRST_DIGIT_RST = 4'd0;
  localparam bit_idx_t LAST_DIGIT_RST  = 4'd9;
  localparam bit_idx_t ENTER_BIT_RST   = 4'd10;
  localparam bit_idx_t CANCEL_BIT_RST  = 4'd11;

endpackage

`default_nettype wire

[rtl/core/kdb_if.sv]
// ----------------------------------------------------------------------------
// kdb_if: channel interfaces of the keypad debounce digit buffer
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Input item channel.
interface kdb_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          cmd;
  kdb_pkg::key_word_t  key_status;
  kdb_pkg::bit_idx_t   read_index;

  modport source (output valid, cmd, key_status, read_index, input ready);
  modport sink   (input valid, cmd, key_status, read_index, output ready);
endinterface

// Result item channel.
interface kdb_out_if;
  logic               valid;
  logic               ready;
  logic               entered;
  logic               cancelled;
  logic [3:0]         digit_count;
  kdb_pkg::bit_idx_t  entry_value;

  modport source (output valid, entered, cancelled, digit_count, entry_value, input ready);
  modport sink   (input valid, entered, cancelled, digit_count, entry_value, output ready);
endinterface

// Configuration write channel.
interface kdb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [kdb_pkg::CFG_IDX_W-1:0]      index;
  kdb_pkg::bit_idx_t                  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/keypad_debounce_digit_buffer.sv]
// ----------------------------------------------------------------------------
// keypad_debounce_digit_buffer: debounced keypad edge detector with digit store
// Debounces a sampled key bitmap, records digit key presses in a small store
// and keeps enter and cancel press flags.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while out_ch.ready is high and returns
// its result in the cycle after acceptance; a new item is accepted in the
// same cycle as the previous result is taken, which sustains that rate. The
// single state update per item (compare with the previous sample, rising-edge
// detect and a lowest-digit priority encode) sits between the state
// registers, and the store is a one-write, one-read memory whose registered
// read port drives entry_value. The store is cleared instantly by per-entry
// valid bits, so there is no clearing pass after reset. digit_count shows the
// low four bits of the store count, which wraps to zero at STORE_DEPTH.
`default_nettype none

module keypad_debounce_digit_buffer #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  kdb_in_if.sink       in_ch,
  kdb_out_if.source    out_ch,
  kdb_cfg_if.sink      cfg_ch
);

  localparam int unsigned CW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned XW  = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] CNT_LAST = CW'(STORE_DEPTH - 1);

  // Configuration registers.
  kdb_pkg::bit_idx_t first_digit_r, last_digit_r, enter_bit_r, cancel_bit_r;

  // Debounce and flag state.
  kdb_pkg::key_word_t last_sample_r, stable_prev_r;
  logic               enter_flag_r, cancel_flag_r;
  logic [CW-1:0]      count_r;
  logic [STORE_DEPTH-1:0] valid_r;

  // Digit store and its registered read port.
  kdb_pkg::bit_idx_t  store_mem [STORE_DEPTH];
  kdb_pkg::bit_idx_t  rd_data_r;
  logic               rd_ok_r;
  logic               out_valid_r;

  logic               in_acc;
  kdb_pkg::cmd_t      cmd;
  logic               stable;
  kdb_pkg::key_word_t rise;
  logic               digit_hit;
  kdb_pkg::bit_idx_t  digit_idx;
  logic               wr_en;
  logic [CW-1:0]      count_inc;
  logic [XW-1:0]      ridx_ext;
  logic [CW-1:0]      rd_addr;
  logic               rd_in_range;
  logic [XW-1:0]      count_ext;

  // Handshake: the result register frees up when it is empty or being taken.
  assign in_ch.ready  = rst_n && (!out_valid_r || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cmd          = kdb_pkg::cmd_t'(in_ch.cmd);

  // Debounce and rising-edge detection.
  assign stable = (in_ch.key_status == last_sample_r);
  assign rise   = in_ch.key_status & ~stable_prev_r;

  // Lowest digit key in the configured range with a rising edge.
  always_comb begin
    digit_hit = 1'b0;
    digit_idx = '0;
    for (int k = kdb_pkg::KEY_W - 1; k >= 0; k--) begin
      if (rise[k] && (4'(k) >= first_digit_r) && (4'(k) <= last_digit_r)) begin
        digit_hit = 1'b1;
        digit_idx = 4'(k);
      end
    end
  end

  assign wr_en     = in_acc && (cmd == kdb_pkg::CMD_TICK) && stable && digit_hit;
  assign count_inc = (count_r == CNT_LAST) ? '0 : count_r + 1'b1;

  // Read address and range check.
  assign ridx_ext    = XW'(in_ch.read_index);
  assign rd_addr     = ridx_ext[CW-1:0];
  assign rd_in_range = (32'(in_ch.read_index) < STORE_DEPTH);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_digit_r <= kdb_pkg::FIRST_DIGIT_RST;
      last_digit_r  <= kdb_pkg::LAST_DIGIT_RST;
      enter_bit_r   <= kdb_pkg::ENTER_BIT_RST;
      cancel_bit_r  <= kdb_pkg::CANCEL_BIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (kdb_pkg::reg_idx_t'(cfg_ch.index))
        kdb_pkg::REG_FIRST_DIGIT: first_digit_r <= cfg_ch.data;
        kdb_pkg::REG_LAST_DIGIT:  last_digit_r  <= cfg_ch.data;
        kdb_pkg::REG_ENTER_BIT:   enter_bit_r   <= cfg_ch.data;
        kdb_pkg::REG_CANCEL_BIT:  cancel_bit_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Item state update and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      stable_prev_r <= '0;
      enter_flag_r  <= 1'b0;
      cancel_flag_r <= 1'b0;
      count_r       <= '0;
      valid_r       <= '0;
      rd_ok_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // The result stays until it is taken; an accepted item reloads it.
      out_valid_r <= in_acc || (out_valid_r && !out_ch.ready);
      if (in_acc) begin
        rd_ok_r <= (cmd == kdb_pkg::CMD_READ) && rd_in_range && valid_r[rd_addr];
        unique case (cmd)
          kdb_pkg::CMD_TICK: begin
            last_sample_r <= in_ch.key_status;
            if (stable) begin
              stable_prev_r <= in_ch.key_status;
              enter_flag_r  <= rise[enter_bit_r];
              cancel_flag_r <= rise[cancel_bit_r];
              if (digit_hit) begin
                valid_r[count_r] <= 1'b1;
                count_r          <= count_inc;
              end
            end
          end
          kdb_pkg::CMD_CLR_ENTER:  enter_flag_r  <= 1'b0;
          kdb_pkg::CMD_CLR_CANCEL: cancel_flag_r <= 1'b0;
          kdb_pkg::CMD_CLR_STORE: begin
            valid_r <= '0;
            count_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Digit store memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[count_r] <= digit_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (cmd == kdb_pkg::CMD_READ) && rd_in_range) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // Result fields; state registers change only when an item is accepted.
  assign count_ext          = XW'(count_r);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.entered     = enter_flag_r;
  assign out_ch.cancelled   = cancel_flag_r;
  assign out_ch.digit_count = count_ext[3:0];
  assign out_ch.entry_value = rd_ok_r ? rd_data_r : '0;

  // Assertions.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) < STORE_DEPTH)
    else $error("store count out of range");

  a_clear_store: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (cmd == kdb_pkg::CMD_CLR_STORE) |=> out_ch.digit_count == 4'd0 && valid_r == '0)
    else $error("store not cleared by clear command");

  a_clear_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (cmd == kdb_pkg::CMD_CLR_ENTER) |=> !out_ch.entered)
    else $error("enter flag not cleared");

  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (cmd != kdb_pkg::CMD_READ) |=> out_ch.entry_value == '0)
    else $error("entry value nonzero without read command");

  a_unstable_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (cmd == kdb_pkg::CMD_TICK) && !stable |=> $stable(stable_prev_r) && $stable(count_r))
    else $error("unstable sample changed debounced state");

endmodule

`default_nettype wire
